/* hdl/smdt_pkg.sv */
package smdt_pkg;

    // default table geometry
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int HANDLE_BITS_DEF   = 32;

    // backing store kind of a real file
    localparam logic [7:0] KIND_REAL_FILE = 8'd2;

    // configuration register index, taken from paddr[2]
    localparam logic REG_BACKEND_PRESENT = 1'b0;

    // request codes
    typedef enum logic [2:0] {
        FUNC_REGISTER   = 3'd0,
        FUNC_UNREGISTER = 3'd1,
        FUNC_MARK_DIRTY = 3'd2,
        FUNC_FLUSH      = 3'd3,
        FUNC_WB_DONE    = 3'd4
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_WB_REQ  = 2'd2,
        STATUS_WR_FAIL = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // what the table walk looks for
    typedef enum logic [1:0] {
        MODE_FREE,   // first inactive entry
        MODE_BASE,   // active entry with matching base
        MODE_HOLD,   // active entry holding the address
        MODE_OVL     // active entry overlapping the range
    } mode_t;

endpackage

/* hdl/shared_mapping_dirty_tracker.sv */
// Table of file-backed shared mappings with dirty tracking. One request is
// handled at a time: s_ready is high only while the block is idle. Register,
// unregister, mark_dirty and flush walk the table with a single entry
// compare unit, one entry per cycle, fed by registered-read entry memories.
// Unregister of a dirty entry walks the table a second time for its flush.
// writeback_done and unknown codes skip the walk. The result sits in an
// output register, so the next request is taken while it waits for m_ready.
// backend_present lives at byte address 0 of the APB port; no clearing pass
// is needed after reset.
module shared_mapping_dirty_tracker #(
    parameter int TABLE_ENTRIES = smdt_pkg::TABLE_ENTRIES_DEF,
    parameter int HANDLE_BITS   = smdt_pkg::HANDLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [63:0] s_addr,
    input  logic [63:0] s_span,
    input  logic [31:0] s_file_handle,
    input  logic [63:0] s_file_pos,
    input  logic [7:0]  s_kind,
    input  logic [4:0]  s_slot,
    input  logic        s_write_ok,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_entry_index,
    output logic        m_wb_valid,
    output logic [31:0] m_wb_handle,
    output logic [63:0] m_wb_file_pos,
    output logic [63:0] m_wb_source,
    output logic [63:0] m_wb_length,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // entry memories
    logic [63:0]            base_mem   [TABLE_ENTRIES];
    logic [63:0]            span_mem   [TABLE_ENTRIES];
    logic [63:0]            end_mem    [TABLE_ENTRIES];
    logic [63:0]            fpos_mem   [TABLE_ENTRIES];
    logic [HANDLE_BITS-1:0] handle_mem [TABLE_ENTRIES];
    logic [7:0]             kind_mem   [TABLE_ENTRIES];

    logic [63:0]            rd_base_reg;
    logic [63:0]            rd_span_reg;
    logic [63:0]            rd_end_reg;
    logic [63:0]            rd_fpos_reg;
    logic [HANDLE_BITS-1:0] rd_handle_reg;
    logic [7:0]             rd_kind_reg;

    logic                   mem_we;
    logic [IDX_W-1:0]       rd_addr;

    // sequencer and request registers
    smdt_pkg::state_t       state_reg, state_next;
    smdt_pkg::mode_t        mode_reg, mode_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       unreg_idx_reg, unreg_idx_next;
    logic                   unreg_flush_reg, unreg_flush_next;
    logic [63:0]            addr_reg, addr_next;
    logic [63:0]            span_reg, span_next;
    logic [63:0]            end_reg, end_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [63:0]            fpos_reg, fpos_next;
    logic [7:0]             kind_reg, kind_next;

    logic [TABLE_ENTRIES-1:0] active_reg, active_next;
    logic [TABLE_ENTRIES-1:0] dirty_reg, dirty_next;
    logic                     backend_reg, backend_next;

    // pending result
    smdt_pkg::status_t      res_status_reg, res_status_next;
    logic [4:0]             res_index_reg, res_index_next;
    logic                   res_wb_valid_reg, res_wb_valid_next;
    logic [31:0]            res_wb_handle_reg, res_wb_handle_next;
    logic [63:0]            res_wb_fpos_reg, res_wb_fpos_next;
    logic [63:0]            res_wb_source_reg, res_wb_source_next;
    logic [63:0]            res_wb_length_reg, res_wb_length_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic [4:0]             m_index_reg, m_index_next;
    logic                   m_wb_valid_reg, m_wb_valid_next;
    logic [31:0]            m_wb_handle_reg, m_wb_handle_next;
    logic [63:0]            m_wb_fpos_reg, m_wb_fpos_next;
    logic [63:0]            m_wb_source_reg, m_wb_source_next;
    logic [63:0]            m_wb_length_reg, m_wb_length_next;

    logic                   accept;
    logic                   out_free;
    logic                   last_idx;
    logic                   cur_active;
    logic                   cur_dirty;
    logic                   scan_hit;
    logic                   wb_request;
    logic                   cfg_write;

    assign s_ready  = (state_reg == smdt_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = (idx_reg == LAST_IDX);

    // shared entry compare unit
    assign cur_active = active_reg[idx_reg];
    assign cur_dirty  = dirty_reg[idx_reg];

    always_comb begin
        unique case (mode_reg)
            smdt_pkg::MODE_FREE: scan_hit = !cur_active;
            smdt_pkg::MODE_BASE: scan_hit = cur_active && (rd_base_reg == addr_reg);
            smdt_pkg::MODE_HOLD: scan_hit = cur_active && (addr_reg >= rd_base_reg)
                                            && (addr_reg < rd_end_reg);
            smdt_pkg::MODE_OVL:  scan_hit = cur_active && (addr_reg < rd_end_reg)
                                            && (end_reg > rd_base_reg);
            default:             scan_hit = 1'b0;
        endcase
    end

    assign wb_request = (rd_kind_reg == smdt_pkg::KIND_REAL_FILE) && backend_reg;

    // entry memories, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            base_mem[idx_reg]   <= addr_reg;
            span_mem[idx_reg]   <= span_reg;
            end_mem[idx_reg]    <= end_reg;
            fpos_mem[idx_reg]   <= fpos_reg;
            handle_mem[idx_reg] <= handle_reg;
            kind_mem[idx_reg]   <= kind_reg;
        end
        rd_base_reg   <= base_mem[rd_addr];
        rd_span_reg   <= span_mem[rd_addr];
        rd_end_reg    <= end_mem[rd_addr];
        rd_fpos_reg   <= fpos_mem[rd_addr];
        rd_handle_reg <= handle_mem[rd_addr];
        rd_kind_reg   <= kind_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smdt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_func == smdt_pkg::FUNC_REGISTER || s_func == smdt_pkg::FUNC_UNREGISTER
                        || s_func == smdt_pkg::FUNC_MARK_DIRTY
                        || s_func == smdt_pkg::FUNC_FLUSH) begin
                        state_next = smdt_pkg::ST_SCAN;
                    end else begin
                        state_next = smdt_pkg::ST_RESP;
                    end
                end
            end
            smdt_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    if (!(mode_reg == smdt_pkg::MODE_BASE && cur_dirty)) begin
                        state_next = smdt_pkg::ST_RESP;
                    end
                end else if (last_idx) begin
                    state_next = smdt_pkg::ST_RESP;
                end
            end
            smdt_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = smdt_pkg::ST_IDLE;
                end
            end
            default: state_next = smdt_pkg::ST_IDLE;
        endcase
    end

    // datapath and table updates
    always_comb begin
        mode_next          = mode_reg;
        idx_next           = idx_reg;
        unreg_idx_next     = unreg_idx_reg;
        unreg_flush_next   = unreg_flush_reg;
        addr_next          = addr_reg;
        span_next          = span_reg;
        end_next           = end_reg;
        handle_next        = handle_reg;
        fpos_next          = fpos_reg;
        kind_next          = kind_reg;
        active_next        = active_reg;
        dirty_next         = dirty_reg;
        res_status_next    = res_status_reg;
        res_index_next     = res_index_reg;
        res_wb_valid_next  = res_wb_valid_reg;
        res_wb_handle_next = res_wb_handle_reg;
        res_wb_fpos_next   = res_wb_fpos_reg;
        res_wb_source_next = res_wb_source_reg;
        res_wb_length_next = res_wb_length_reg;
        mem_we             = 1'b0;
        rd_addr            = '0;

        unique case (state_reg)
            smdt_pkg::ST_IDLE: begin
                if (accept) begin
                    addr_next          = s_addr;
                    span_next          = s_span;
                    end_next           = s_addr + s_span;
                    handle_next        = HANDLE_BITS'(s_file_handle);
                    fpos_next          = s_file_pos;
                    kind_next          = s_kind;
                    idx_next           = '0;
                    unreg_flush_next   = 1'b0;
                    res_status_next    = smdt_pkg::STATUS_OK;
                    res_index_next     = '0;
                    res_wb_valid_next  = 1'b0;
                    res_wb_handle_next = '0;
                    res_wb_fpos_next   = '0;
                    res_wb_source_next = '0;
                    res_wb_length_next = '0;
                    unique case (s_func)
                        smdt_pkg::FUNC_REGISTER:   mode_next = smdt_pkg::MODE_FREE;
                        smdt_pkg::FUNC_UNREGISTER: mode_next = smdt_pkg::MODE_BASE;
                        smdt_pkg::FUNC_MARK_DIRTY: mode_next = smdt_pkg::MODE_HOLD;
                        smdt_pkg::FUNC_FLUSH:      mode_next = smdt_pkg::MODE_OVL;
                        smdt_pkg::FUNC_WB_DONE: begin
                            res_status_next = s_write_ok ? smdt_pkg::STATUS_OK
                                                         : smdt_pkg::STATUS_WR_FAIL;
                            res_index_next  = s_slot;
                            // slots beyond the table decode to nothing
                            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                                if (s_write_ok && (32'(s_slot) == k)) begin
                                    dirty_next[k] = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            smdt_pkg::ST_SCAN: begin
                rd_addr  = (scan_hit || last_idx) ? '0 : idx_reg + IDX_W'(1);
                idx_next = idx_reg + IDX_W'(1);
                if (scan_hit) begin
                    unique case (mode_reg)
                        smdt_pkg::MODE_FREE: begin
                            mem_we               = 1'b1;
                            active_next[idx_reg] = 1'b1;
                            dirty_next[idx_reg]  = 1'b0;
                            res_index_next       = 5'(idx_reg);
                        end
                        smdt_pkg::MODE_BASE: begin
                            if (cur_dirty) begin
                                // flush over the entry's own range, walk again
                                unreg_idx_next   = idx_reg;
                                unreg_flush_next = 1'b1;
                                mode_next        = smdt_pkg::MODE_OVL;
                                span_next        = rd_span_reg;
                                end_next         = rd_end_reg;
                                idx_next         = '0;
                            end else begin
                                active_next[idx_reg] = 1'b0;
                                res_index_next       = 5'(idx_reg);
                            end
                        end
                        smdt_pkg::MODE_HOLD: begin
                            dirty_next[idx_reg] = 1'b1;
                        end
                        smdt_pkg::MODE_OVL: begin
                            res_index_next = 5'(idx_reg);
                            if (wb_request) begin
                                res_status_next    = smdt_pkg::STATUS_WB_REQ;
                                res_wb_valid_next  = 1'b1;
                                res_wb_handle_next = 32'(rd_handle_reg);
                                res_wb_fpos_next   = rd_fpos_reg;
                                res_wb_source_next = rd_base_reg;
                                res_wb_length_next = (rd_span_reg > span_reg) ? span_reg
                                                                              : rd_span_reg;
                            end else begin
                                dirty_next[idx_reg] = 1'b0;
                            end
                            if (unreg_flush_reg) begin
                                active_next[unreg_idx_reg] = 1'b0;
                                if (!wb_request) begin
                                    res_index_next = 5'(unreg_idx_reg);
                                end
                            end
                        end
                        default: ;
                    endcase
                end else if (last_idx) begin
                    // walk ended without a match
                    if (mode_reg == smdt_pkg::MODE_FREE) begin
                        res_status_next = smdt_pkg::STATUS_FULL;
                    end else if (mode_reg == smdt_pkg::MODE_OVL && unreg_flush_reg) begin
                        active_next[unreg_idx_reg] = 1'b0;
                        res_index_next             = 5'(unreg_idx_reg);
                    end
                end
            end
            smdt_pkg::ST_RESP: ;
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_index_next     = m_index_reg;
        m_wb_valid_next  = m_wb_valid_reg;
        m_wb_handle_next = m_wb_handle_reg;
        m_wb_fpos_next   = m_wb_fpos_reg;
        m_wb_source_next = m_wb_source_reg;
        m_wb_length_next = m_wb_length_reg;
        if (state_reg == smdt_pkg::ST_RESP && out_free) begin
            m_valid_next     = 1'b1;
            m_status_next    = res_status_reg;
            m_index_next     = res_index_reg;
            m_wb_valid_next  = res_wb_valid_reg;
            m_wb_handle_next = res_wb_handle_reg;
            m_wb_fpos_next   = res_wb_fpos_reg;
            m_wb_source_next = res_wb_source_reg;
            m_wb_length_next = res_wb_length_reg;
        end
    end

    // configuration port
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == smdt_pkg::REG_BACKEND_PRESENT);
    assign backend_next = cfg_write ? pwdata[0] : backend_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == smdt_pkg::REG_BACKEND_PRESENT) ? {31'd0, backend_reg} : '0;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= smdt_pkg::ST_IDLE;
            mode_reg        <= smdt_pkg::MODE_FREE;
            idx_reg         <= '0;
            unreg_flush_reg <= 1'b0;
            active_reg      <= '0;
            dirty_reg       <= '0;
            backend_reg     <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            unreg_flush_reg <= unreg_flush_next;
            active_reg      <= active_next;
            dirty_reg       <= dirty_next;
            backend_reg     <= backend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unreg_idx_reg     <= unreg_idx_next;
        addr_reg          <= addr_next;
        span_reg          <= span_next;
        end_reg           <= end_next;
        handle_reg        <= handle_next;
        fpos_reg          <= fpos_next;
        kind_reg          <= kind_next;
        res_status_reg    <= res_status_next;
        res_index_reg     <= res_index_next;
        res_wb_valid_reg  <= res_wb_valid_next;
        res_wb_handle_reg <= res_wb_handle_next;
        res_wb_fpos_reg   <= res_wb_fpos_next;
        res_wb_source_reg <= res_wb_source_next;
        res_wb_length_reg <= res_wb_length_next;
        m_status_reg      <= m_status_next;
        m_index_reg       <= m_index_next;
        m_wb_valid_reg    <= m_wb_valid_next;
        m_wb_handle_reg   <= m_wb_handle_next;
        m_wb_fpos_reg     <= m_wb_fpos_next;
        m_wb_source_reg   <= m_wb_source_next;
        m_wb_length_reg   <= m_wb_length_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_wb_valid    = m_wb_valid_reg;
    assign m_wb_handle   = m_wb_handle_reg;
    assign m_wb_file_pos = m_wb_fpos_reg;
    assign m_wb_source   = m_wb_source_reg;
    assign m_wb_length   = m_wb_length_reg;

endmodule
